// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the integer-to-Roman converter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while reset is released.
`define RTN_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds on a rising clock edge while reset is released.
`define RTN_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/rtn_pkg.sv =====
// Types, constants and symbol tables for the integer-to-Roman converter.
`timescale 1ns / 1ps
`default_nettype none

package rtn_pkg;

	localparam int unsigned NUM_W      = 12;
	localparam int unsigned SYM_W      = 8;
	localparam int unsigned CONV_STEPS = NUM_W;
	localparam logic [NUM_W-1:0] MAX_NUMBER = 12'd3999;

	localparam logic [SYM_W-1:0] SYM_NONE = 8'h00;
	localparam logic [SYM_W-1:0] SYM_I    = 8'h49;
	localparam logic [SYM_W-1:0] SYM_V    = 8'h56;
	localparam logic [SYM_W-1:0] SYM_X    = 8'h58;
	localparam logic [SYM_W-1:0] SYM_L    = 8'h4C;
	localparam logic [SYM_W-1:0] SYM_C    = 8'h43;
	localparam logic [SYM_W-1:0] SYM_D    = 8'h44;
	localparam logic [SYM_W-1:0] SYM_M    = 8'h4D;

	// Decimal positions.
	localparam logic [1:0] POS_ONES      = 2'd0;
	localparam logic [1:0] POS_TENS      = 2'd1;
	localparam logic [1:0] POS_HUNDREDS  = 2'd2;
	localparam logic [1:0] POS_THOUSANDS = 2'd3;

	// Symbol slots within a position.
	localparam logic [1:0] SLOT_UNIT = 2'd0;
	localparam logic [1:0] SLOT_FIVE = 2'd1;
	localparam logic [1:0] SLOT_NEXT = 2'd2;

	// One decimal digit handed from the front end to the back end.
	typedef struct packed {
		logic       is_empty;
		logic       is_last;
		logic [1:0] pos;
		logic [3:0] digit;
	} rtn_entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_PUSH
	} rtn_front_state_t;

	// Index of the final character in the pattern of a digit.
	function automatic logic [1:0] pat_last_idx(input logic [3:0] digit);
		logic [1:0] idx;
		case (digit)
			4'd2, 4'd4, 4'd6, 4'd9: idx = 2'd1;
			4'd3, 4'd7:             idx = 2'd2;
			4'd8:                   idx = 2'd3;
			default:                idx = 2'd0;
		endcase
		return idx;
	endfunction

	// Symbol slot of character k in the pattern of a digit.
	function automatic logic [1:0] pat_slot(input logic [3:0] digit, input logic [1:0] k);
		logic [1:0] slot;
		case (digit)
			4'd4: begin
				slot = (k == 2'd0) ? SLOT_UNIT : SLOT_FIVE;
			end
			4'd5, 4'd6, 4'd7, 4'd8: begin
				slot = (k == 2'd0) ? SLOT_FIVE : SLOT_UNIT;
			end
			4'd9: begin
				slot = (k == 2'd0) ? SLOT_UNIT : SLOT_NEXT;
			end
			default: begin
				slot = SLOT_UNIT;
			end
		endcase
		return slot;
	endfunction

	// ASCII symbol for a slot at a decimal position.
	function automatic logic [SYM_W-1:0] pos_sym(input logic [1:0] pos, input logic [1:0] slot);
		logic [SYM_W-1:0] s;
		case (pos)
			POS_ONES: begin
				s = (slot == SLOT_UNIT) ? SYM_I : (slot == SLOT_FIVE) ? SYM_V : SYM_X;
			end
			POS_TENS: begin
				s = (slot == SLOT_UNIT) ? SYM_X : (slot == SLOT_FIVE) ? SYM_L : SYM_C;
			end
			POS_HUNDREDS: begin
				s = (slot == SLOT_UNIT) ? SYM_C : (slot == SLOT_FIVE) ? SYM_D : SYM_M;
			end
			default: begin
				s = SYM_M;
			end
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rtn_front.sv =====
// Front end: queues the nonzero decimal digits of a number, or an empty entry for zero.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rtn_front
	import rtn_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] number,
	output logic                  busy,
	output logic                  push,
	output rtn_entry_t            push_entry,
	input  wire logic             full
);

	localparam int unsigned CNT_W = $clog2(CONV_STEPS);

	rtn_front_state_t state_q, state_d;

	logic [NUM_W-1:0] bin_q;
	logic [15:0]      bcd_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       pos_q;

	logic [NUM_W-1:0] sat_num;
	logic [15:0]      bcd_adj;
	logic [1:0]       low_pos;
	logic [3:0]       cur_digit;
	logic             load;
	logic             step;
	logic             enter_push;
	logic             pos_dec;

	// Out-of-range inputs saturate to the largest numeral.
	assign sat_num = (number > MAX_NUMBER) ? MAX_NUMBER : number;

	// Shift-and-add-three correction, one per BCD digit.
	always_comb begin
		bcd_adj = bcd_q;
		for (int i = 0; i < 4; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end
		end
	end

	// Lowest nonzero decimal position; its pattern carries the final character.
	always_comb begin
		if (bcd_q[3:0] != 4'd0) begin
			low_pos = POS_ONES;
		end else if (bcd_q[7:4] != 4'd0) begin
			low_pos = POS_TENS;
		end else if (bcd_q[11:8] != 4'd0) begin
			low_pos = POS_HUNDREDS;
		end else begin
			low_pos = POS_THOUSANDS;
		end
	end

	assign cur_digit = bcd_q[{pos_q, 2'b00} +: 4];

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and queue requests.
	always_comb begin
		state_d    = state_q;
		busy       = 1'b1;
		load       = 1'b0;
		step       = 1'b0;
		enter_push = 1'b0;
		pos_dec    = 1'b0;
		push       = 1'b0;
		push_entry = '{is_empty: 1'b0, is_last: 1'b0, pos: pos_q, digit: cur_digit};
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					load    = 1'b1;
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				step = 1'b1;
				if (cnt_q == '0) begin
					enter_push = 1'b1;
					state_d    = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (bcd_q == 16'd0) begin
					// Zero gives a single empty request.
					push_entry.is_empty = 1'b1;
					push_entry.is_last  = 1'b1;
					if (!full) begin
						push    = 1'b1;
						state_d = ST_IDLE;
					end
				end else if (cur_digit == 4'd0) begin
					pos_dec = 1'b1;
				end else begin
					push_entry.is_last = (pos_q == low_pos);
					if (!full) begin
						push = 1'b1;
						if (pos_q == low_pos) begin
							state_d = ST_IDLE;
						end else begin
							pos_dec = 1'b1;
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Conversion datapath: one binary bit shifts into the BCD register per cycle.
	always_ff @(posedge clk) begin
		if (load) begin
			bin_q <= sat_num;
			bcd_q <= '0;
			cnt_q <= CNT_W'(CONV_STEPS - 1);
		end else if (step) begin
			bcd_q <= {bcd_adj[14:0], bin_q[NUM_W-1]};
			bin_q <= {bin_q[NUM_W-2:0], 1'b0};
			cnt_q <= cnt_q - 1'b1;
		end
		if (enter_push) begin
			pos_q <= POS_THOUSANDS;
		end else if (pos_dec) begin
			pos_q <= pos_q - 1'b1;
		end
	end

	`RTN_ASSERT(a_busy_after_start, clk, arst_n, $rose(busy) |-> $past(start), "front went busy without a request")
	`RTN_NEVER(a_push_zero_digit, clk, arst_n, push && !push_entry.is_empty && push_entry.digit == 4'd0, "zero digit queued")
	`RTN_NEVER(a_push_when_full, clk, arst_n, push && full, "queue written while full")

endmodule

`default_nettype wire

// ===== hw/rtl/rtn_fifo.sv =====
// Short queue of digit requests between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rtn_fifo
	import rtn_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire rtn_entry_t push_entry,
	output logic            full,
	input  wire logic       pop,
	output rtn_entry_t      head,
	output logic            empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	rtn_entry_t    mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	`RTN_NEVER(a_pop_when_empty, clk, arst_n, pop && empty, "queue read while empty")

endmodule

`default_nettype wire

// ===== hw/rtl/rtn_back.sv =====
// Back end: expands each queued digit into its Roman characters, one per cycle while the queue is not empty.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rtn_back
	import rtn_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire rtn_entry_t       head,
	input  wire logic             empty,
	output logic                  pop,
	output logic                  strobe,
	output logic [SYM_W-1:0]      symbol,
	output logic                  last,
	output logic                  empty_res
);

	logic [1:0]       k_q;
	logic             strobe_q;
	logic [SYM_W-1:0] symbol_q;
	logic             last_q;
	logic             empty_res_q;

	logic             head_valid;
	logic             char_end;
	logic [SYM_W-1:0] cur_sym;

	// Current character of the digit at the queue head.
	assign head_valid = !empty;
	assign char_end   = head.is_empty || (k_q == pat_last_idx(head.digit));
	assign pop        = head_valid && char_end;
	assign cur_sym    = head.is_empty ? SYM_NONE :
		pos_sym(head.pos, pat_slot(head.digit, k_q));

	// Character index and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			strobe_q    <= 1'b0;
			last_q      <= 1'b0;
			empty_res_q <= 1'b0;
		end else begin
			if (pop) begin
				k_q <= '0;
			end else if (head_valid) begin
				k_q <= k_q + 1'b1;
			end
			strobe_q    <= head_valid;
			last_q      <= pop && head.is_last;
			empty_res_q <= head_valid && head.is_empty;
		end
	end

	always_ff @(posedge clk) begin
		symbol_q <= cur_sym;
	end

	assign strobe    = strobe_q;
	assign symbol    = symbol_q;
	assign last      = last_q;
	assign empty_res = empty_res_q;

	`RTN_ASSERT(a_last_has_strobe, clk, arst_n, last_q |-> strobe_q, "last flag without a result")
	`RTN_ASSERT(a_empty_is_single, clk, arst_n, empty_res_q |-> (last_q && symbol_q == SYM_NONE), "empty result malformed")

endmodule

`default_nettype wire

// ===== hw/rtl/integer_to_roman_numeral.sv =====
// Integer to Roman numeral converter: top level joining front end, queue and back end.
// The first character appears after the binary-to-decimal shift loop, the walk past leading
// zero positions, the queue and the output register, later if the queue is full. The front
// end is busy for the shift loop and each position it walks, and takes a new request once
// its last digit is queued, even while the back end still emits; reset clears control state.
// Back end: one character per cycle while the queue is not empty, with no receiver stall.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_roman_numeral
	import rtn_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] number,
	output logic                  busy,
	output logic                  strobe,
	output logic [SYM_W-1:0]      symbol,
	output logic                  last,
	output logic                  empty_res
);

	rtn_entry_t push_entry;
	rtn_entry_t head;
	logic       push;
	logic       full;
	logic       pop;
	logic       empty;

	rtn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.number     (number),
		.busy       (busy),
		.push       (push),
		.push_entry (push_entry),
		.full       (full)
	);

	rtn_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.empty      (empty)
	);

	rtn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.strobe    (strobe),
		.symbol    (symbol),
		.last      (last),
		.empty_res (empty_res)
	);

endmodule

`default_nettype wire
